### rtl/core/bvm_pkg.sv
package bvm_pkg;

	localparam int DEF_STACK_DEPTH = 16;
	localparam int DEF_INDEX_WIDTH = 16;
	localparam logic [11:0] START_ADDRESS_RST = 12'd512;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EXIT  = 3'd1,
		ST_CLS   = 3'd2,
		ST_UNSUP = 3'd3,
		ST_STACK = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		OP_SYS  = 4'h0,
		OP_JP   = 4'h1,
		OP_CALL = 4'h2,
		OP_SE   = 4'h3,
		OP_SNE  = 4'h4,
		OP_SER  = 4'h5,
		OP_LD   = 4'h6,
		OP_ADD  = 4'h7,
		OP_ALU  = 4'h8,
		OP_SNER = 4'h9,
		OP_LDI  = 4'hA,
		OP_JPV  = 4'hB,
		OP_RND  = 4'hC,
		OP_DRW  = 4'hD,
		OP_KEY  = 4'hE,
		OP_MISC = 4'hF
	} op_t;

	typedef enum logic [3:0] {
		ALU_MOV  = 4'h0,
		ALU_OR   = 4'h1,
		ALU_AND  = 4'h2,
		ALU_XOR  = 4'h3,
		ALU_ADD  = 4'h4,
		ALU_SUB  = 4'h5,
		ALU_SHR  = 4'h6,
		ALU_SUBN = 4'h7,
		ALU_SHL  = 4'hE
	} alu_t;

	localparam logic [11:0] SYS_CLS  = 12'h0E0;
	localparam logic [11:0] SYS_RET  = 12'h0EE;
	localparam logic [11:0] SYS_EXIT = 12'h0FD;
	localparam logic [11:0] SYS_HALT = 12'h000;

	localparam logic [7:0] F_LD_DT  = 8'h07;
	localparam logic [7:0] F_SET_DT = 8'h15;
	localparam logic [7:0] F_SET_ST = 8'h18;
	localparam logic [7:0] F_ADD_I  = 8'h1E;

	localparam logic [3:0] REG_VF = 4'hF;
	localparam logic [3:0] REG_V0 = 4'h0;

	typedef struct packed {
		logic [15:0] instruction;
		logic [7:0]  rand_val;
	} item_t;

	typedef struct packed {
		logic [11:0] next_pc;
		logic [2:0]  status;
		logic        reg_write;
		logic [3:0]  dest_reg;
		logic [7:0]  reg_value;
		logic        flag_value;
		logic [15:0] index_value;
		logic [7:0]  delay_value;
		logic [7:0]  sound_value;
	} result_t;

	// Write-back controls from the execute logic.
	typedef struct packed {
		logic        mem_we;
		logic [3:0]  mem_addr;
		logic [7:0]  mem_data;
		logic        vf_we;
		logic [7:0]  vf_data;
		logic        push;
		logic        pop;
		logic [11:0] push_data;
		logic        delay_we;
		logic        sound_we;
		logic        index_we;
	} wb_t;

endpackage

### rtl/core/bvm_regfile.sv
module bvm_regfile (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rd_en,
	input  logic [3:0] rd_addr_a,
	input  logic [3:0] rd_addr_b,
	input  logic       wr_en,
	input  logic [3:0] wr_addr,
	input  logic [7:0] wr_data,
	output logic [7:0] rd_data_a,
	output logic [7:0] rd_data_b
);
	import bvm_pkg::*;

	logic [7:0]  mem [16];
	logic [15:0] valid_q;
	logic [7:0]  rd_a_q, rd_b_q;
	logic        vld_a_q, vld_b_q;
	logic [3:0]  addr_a_q, addr_b_q;
	logic        fwd_we_q;
	logic [3:0]  fwd_addr_q;
	logic [7:0]  fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
			addr_a_q <= rd_addr_a;
			addr_b_q <= rd_addr_b;
		end
	end

	// Entries never written read as zero; valid bits stand in for a clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_a_q  <= 1'b0;
			vld_b_q  <= 1'b0;
			fwd_we_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q  <= valid_q[rd_addr_a];
				vld_b_q  <= valid_q[rd_addr_b];
				fwd_we_q <= wr_en;
			end
		end
	end

	// A write in the same cycle as the read lands after the read; forward it.
	assign rd_data_a = (fwd_we_q && fwd_addr_q == addr_a_q) ? fwd_data_q :
		(vld_a_q ? rd_a_q : 8'd0);
	assign rd_data_b = (fwd_we_q && fwd_addr_q == addr_b_q) ? fwd_data_q :
		(vld_b_q ? rd_b_q : 8'd0);

endmodule

### rtl/core/bvm_stack.sv
module bvm_stack #(
	parameter int STACK_DEPTH = bvm_pkg::DEF_STACK_DEPTH,
	localparam int AW = $clog2(STACK_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [11:0]   wr_data,
	output logic [11:0]   rd_data
);
	import bvm_pkg::*;

	logic [11:0] mem [STACK_DEPTH];
	logic [11:0] rd_q;
	logic [11:0] fwd_data_q;
	logic        fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (rd_en) begin
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

### rtl/core/bvm_exec.sv
module bvm_exec #(
	parameter int STACK_DEPTH = bvm_pkg::DEF_STACK_DEPTH,
	parameter int INDEX_WIDTH = bvm_pkg::DEF_INDEX_WIDTH,
	localparam int DW = $clog2(STACK_DEPTH + 1)
) (
	input  bvm_pkg::item_t       item,
	input  logic [7:0]           vx,
	input  logic [7:0]           vy,
	input  logic [7:0]           vf,
	input  logic [11:0]          pc,
	input  logic [INDEX_WIDTH-1:0] index_reg,
	input  logic [7:0]           delay_timer,
	input  logic [7:0]           sound_timer,
	input  logic [DW-1:0]        depth,
	input  logic [11:0]          stack_top,
	output logic [INDEX_WIDTH-1:0] index_next,
	output bvm_pkg::wb_t         wb,
	output bvm_pkg::result_t     res
);
	import bvm_pkg::*;

	localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

	logic [15:0] ins;
	logic [3:0]  x, n;
	logic [7:0]  kk;
	logic [11:0] nnn;
	logic [11:0] pc_next, pc_seq, pc_skip;
	logic [2:0]  st;
	logic        rw, fw, flag;
	logic [7:0]  rv;
	logic [8:0]  sum9;
	logic [7:0]  vf_after;

	always_comb begin
		ins     = item.instruction;
		x       = ins[11:8];
		n       = ins[3:0];
		kk      = ins[7:0];
		nnn     = ins[11:0];
		pc_seq  = pc + 12'd2;
		pc_skip = pc + 12'd4;
		pc_next = pc_seq;
		st      = ST_OK;
		rw      = 1'b0;
		fw      = 1'b0;
		flag    = 1'b0;
		rv      = 8'd0;
		sum9    = {1'b0, vx} + {1'b0, vy};
		wb      = '0;
		index_next = index_reg;

		case (op_t'(ins[15:12]))
			OP_SYS: begin
				if (nnn == SYS_CLS) begin
					st = ST_CLS;
				end else if (nnn == SYS_RET) begin
					if (depth == '0) begin
						st      = ST_STACK;
						pc_next = pc;
					end else begin
						wb.pop  = 1'b1;
						pc_next = stack_top;
					end
				end else if (nnn == SYS_EXIT || nnn == SYS_HALT) begin
					st      = ST_EXIT;
					pc_next = pc;
				end
			end
			OP_JP: pc_next = nnn;
			OP_CALL: begin
				if (depth >= DEPTH_FULL) begin
					st      = ST_STACK;
					pc_next = pc;
				end else begin
					wb.push      = 1'b1;
					wb.push_data = pc_seq;
					pc_next      = nnn;
				end
			end
			OP_SE:   if (vx == kk) pc_next = pc_skip;
			OP_SNE:  if (vx != kk) pc_next = pc_skip;
			OP_SER:  if (vx == vy) pc_next = pc_skip;
			OP_SNER: if (vx != vy) pc_next = pc_skip;
			OP_LD: begin
				rw = 1'b1;
				rv = kk;
			end
			OP_ADD: begin
				rw = 1'b1;
				rv = vx + kk;
			end
			OP_ALU: begin
				rw = 1'b1;
				case (alu_t'(n))
					ALU_MOV: rv = vy;
					ALU_OR:  rv = vx | vy;
					ALU_AND: rv = vx & vy;
					ALU_XOR: rv = vx ^ vy;
					ALU_ADD: begin
						fw   = 1'b1;
						flag = sum9[8];
						rv   = sum9[7:0];
					end
					ALU_SUB: begin
						fw   = 1'b1;
						flag = vx > vy;
						rv   = vx - vy;
					end
					ALU_SHR: begin
						fw   = 1'b1;
						flag = vx[0];
						rv   = {1'b0, vx[7:1]};
					end
					ALU_SUBN: begin
						fw   = 1'b1;
						flag = vy > vx;
						rv   = vy - vx;
					end
					ALU_SHL: begin
						fw   = 1'b1;
						flag = vx[7];
						rv   = {vx[6:0], 1'b0};
					end
					default: begin
						rw      = 1'b0;
						st      = ST_UNSUP;
						pc_next = pc;
					end
				endcase
			end
			OP_LDI: begin
				wb.index_we = 1'b1;
				index_next  = INDEX_WIDTH'(nnn);
			end
			OP_JPV: pc_next = nnn + {4'd0, vy};
			OP_RND: begin
				rw = 1'b1;
				rv = item.rand_val & kk;
			end
			OP_MISC: begin
				if (kk == F_LD_DT) begin
					rw = 1'b1;
					rv = delay_timer;
				end else if (kk == F_SET_DT) begin
					wb.delay_we = 1'b1;
				end else if (kk == F_SET_ST) begin
					wb.sound_we = 1'b1;
				end else if (kk == F_ADD_I) begin
					wb.index_we = 1'b1;
					index_next  = index_reg + INDEX_WIDTH'(vx);
				end else begin
					st      = ST_UNSUP;
					pc_next = pc;
				end
			end
			OP_DRW, OP_KEY: begin
				st      = ST_UNSUP;
				pc_next = pc;
			end
			default: begin
				st      = ST_UNSUP;
				pc_next = pc;
			end
		endcase

		// VF lives outside the memory; when x is VF the result overwrites the flag.
		wb.mem_we   = rw && (x != REG_VF);
		wb.mem_addr = x;
		wb.mem_data = rv;
		wb.vf_we    = (rw && x == REG_VF) || fw;
		wb.vf_data  = (x == REG_VF) ? rv : {7'd0, flag};
		vf_after    = wb.vf_we ? wb.vf_data : vf;

		res.next_pc     = pc_next;
		res.status      = st;
		res.reg_write   = rw;
		res.dest_reg    = rw ? x : 4'd0;
		res.reg_value   = rv;
		res.flag_value  = vf_after[0];
		res.index_value = 16'(index_next);
		res.delay_value = wb.delay_we ? vx : delay_timer;
		res.sound_value = wb.sound_we ? vx : sound_timer;
	end

endmodule

### rtl/core/byte_vm_instruction_executor_core.sv
// Channel  Direction  Handshake                 Payload
// item     in         item_valid/item_stall     item (instruction, rand_val)
// result   out        result_valid/result_stall result (pc, status, register and timer view)
// cfg      in         cfg_valid/cfg_ready       cfg_start_address (12 bits)
//
// One instruction per cycle unless a held result stalls the input; the memories are read
// at the accepting edge, execution follows, and the result register captures the outcome.
// The execute stage writes back at the edge where the next request reads, and a
// forwarding path covers that overlap in both memories.
// Reset clears control state, the register valid bits and VF; the pc loads 512.
// item_stall rises only while a finished result waits and result_stall is high.
module byte_vm_instruction_executor_core #(
	parameter int STACK_DEPTH = bvm_pkg::DEF_STACK_DEPTH,
	parameter int INDEX_WIDTH = bvm_pkg::DEF_INDEX_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  bvm_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output bvm_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [11:0]       cfg_start_address
);
	import bvm_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic                   accept, fire;
	logic                   valid_s1;
	item_t                  item_s1;
	logic [11:0]            pc_q;
	logic [INDEX_WIDTH-1:0] index_q, index_next;
	logic [7:0]             delay_q, sound_q, vf_q;
	logic [DW-1:0]          depth_q, depth_after;
	logic [3:0]             rd_b_addr;
	logic [7:0]             rf_a, rf_b, vx, vy;
	logic [11:0]            stack_top;
	wb_t                    wb;
	result_t                res;
	result_t                result_q;
	logic                   result_valid_q;

	assign fire       = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !fire;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	// Bnnn needs V0 instead of Vy on the second read port.
	assign rd_b_addr = (op_t'(item.instruction[15:12]) == OP_JPV) ? REG_V0 :
		item.instruction[7:4];

	bvm_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (item.instruction[11:8]),
		.rd_addr_b (rd_b_addr),
		.wr_en     (fire && wb.mem_we),
		.wr_addr   (wb.mem_addr),
		.wr_data   (wb.mem_data),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b)
	);

	always_comb begin
		depth_after = depth_q;
		if (fire && wb.push) begin
			depth_after = depth_q + DW'(1);
		end else if (fire && wb.pop) begin
			depth_after = depth_q - DW'(1);
		end
	end

	bvm_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (AW'(depth_after - DW'(1))),
		.wr_en   (fire && wb.push),
		.wr_addr (AW'(depth_q)),
		.wr_data (wb.push_data),
		.rd_data (stack_top)
	);

	assign vx = (item_s1.instruction[11:8] == REG_VF) ? vf_q : rf_a;
	assign vy = (op_t'(item_s1.instruction[15:12]) != OP_JPV &&
		item_s1.instruction[7:4] == REG_VF) ? vf_q : rf_b;

	bvm_exec #(
		.STACK_DEPTH (STACK_DEPTH),
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_exec (
		.item        (item_s1),
		.vx          (vx),
		.vy          (vy),
		.vf          (vf_q),
		.pc          (pc_q),
		.index_reg   (index_q),
		.delay_timer (delay_q),
		.sound_timer (sound_q),
		.depth       (depth_q),
		.stack_top   (stack_top),
		.index_next  (index_next),
		.wb          (wb),
		.res         (res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (fire) begin
			result_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			pc_q           <= START_ADDRESS_RST;
			index_q        <= '0;
			delay_q        <= '0;
			sound_q        <= '0;
			vf_q           <= '0;
			depth_q        <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				pc_q <= cfg_start_address;
			end else if (fire) begin
				pc_q <= res.next_pc;
			end
			if (fire) begin
				depth_q <= depth_after;
				if (wb.index_we) begin
					index_q <= index_next;
				end
				if (wb.delay_we) begin
					delay_q <= vx;
				end
				if (wb.sound_we) begin
					sound_q <= vx;
				end
				if (wb.vf_we) begin
					vf_q <= wb.vf_data;
				end
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bvm_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DIRECTED_ROWS = 26;
	localparam int TYPED_ROWS = 7;
	localparam int PHASE_ITEMS = 306;
	localparam int BURST_CALLS = DEF_STACK_DEPTH + 2;
	localparam int HOLD_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [11:0] cfg_start_address = '0;

	// Machine state as the predictor sees it.
	logic [7:0] v_regs [16];
	logic [15:0] i_reg;
	logic [11:0] pc_reg;
	logic [11:0] call_stack [DEF_STACK_DEPTH];
	int call_depth;
	logic [7:0] delay_reg;
	logic [7:0] sound_reg;

	result_t exec_results_due [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int cycles = 0;

	// Directed requests; the first rows carry results worked out by hand from reset.
	logic [15:0] dir_words [DIRECTED_ROWS] = '{
		16'h0000, 16'h00FD, 16'h00EE, 16'h00E0, 16'h60FF, 16'h6FFF, 16'h7001,
		16'h6A80, 16'h6B81, 16'h8AB4, 16'h8AB5, 16'h8AB7, 16'h8A0E, 16'h8FA4,
		16'h5AB7, 16'hAFFF, 16'hFA1E, 16'hFB15, 16'hFB18, 16'hCDFF, 16'h22FE,
		16'h00EE, 16'hBFFF, 16'hD123, 16'h8ABF, 16'hF00A
	};
	logic [7:0] dir_random [DIRECTED_ROWS] = '{
		8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
		8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hA5,
		8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF
	};
	result_t typed_results [TYPED_ROWS] = '{
		'{12'h200, ST_EXIT, 1'b0, 4'h0, 8'h00, 1'b0, 16'h0000, 8'h00, 8'h00},
		'{12'h200, ST_EXIT, 1'b0, 4'h0, 8'h00, 1'b0, 16'h0000, 8'h00, 8'h00},
		'{12'h200, ST_STACK, 1'b0, 4'h0, 8'h00, 1'b0, 16'h0000, 8'h00, 8'h00},
		'{12'h202, ST_CLS, 1'b0, 4'h0, 8'h00, 1'b0, 16'h0000, 8'h00, 8'h00},
		'{12'h204, ST_OK, 1'b1, 4'h0, 8'hFF, 1'b0, 16'h0000, 8'h00, 8'h00},
		'{12'h206, ST_OK, 1'b1, 4'hF, 8'hFF, 1'b1, 16'h0000, 8'h00, 8'h00},
		'{12'h208, ST_OK, 1'b1, 4'h0, 8'h00, 1'b1, 16'h0000, 8'h00, 8'h00}
	};

	byte_vm_instruction_executor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_start_address(cfg_start_address)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic result_t execute_instruction(item_t req);
		result_t r;
		op_t op;
		logic [3:0] x;
		logic [3:0] n;
		logic [7:0] kk;
		logic [7:0] vx;
		logic [7:0] vy;
		logic [7:0] val;
		logic [8:0] sum;
		logic [11:0] nnn;
		logic [11:0] next;
		logic wr;
		logic with_flag;
		logic flag;
		op = op_t'(req.instruction[15:12]);
		x = req.instruction[11:8];
		n = req.instruction[3:0];
		kk = req.instruction[7:0];
		nnn = req.instruction[11:0];
		vx = v_regs[x];
		vy = v_regs[req.instruction[7:4]];
		r = '0;
		r.status = ST_OK;
		next = pc_reg + 12'd2;
		wr = 1'b0;
		with_flag = 1'b0;
		flag = 1'b0;
		val = 8'h00;
		case (op)
			OP_SYS: begin
				if (nnn == SYS_CLS) begin
					r.status = ST_CLS;
				end else if (nnn == SYS_RET) begin
					if (call_depth == 0) begin
						r.status = ST_STACK;
						next = pc_reg;
					end else begin
						call_depth--;
						next = call_stack[call_depth];
					end
				end else if (nnn == SYS_EXIT || nnn == SYS_HALT) begin
					r.status = ST_EXIT;
					next = pc_reg;
				end
			end
			OP_JP: next = nnn;
			OP_CALL: begin
				if (call_depth >= DEF_STACK_DEPTH) begin
					r.status = ST_STACK;
					next = pc_reg;
				end else begin
					call_stack[call_depth] = pc_reg + 12'd2;
					call_depth++;
					next = nnn;
				end
			end
			OP_SE: if (vx == kk) next = pc_reg + 12'd4;
			OP_SNE: if (vx != kk) next = pc_reg + 12'd4;
			OP_SER: if (vx == vy) next = pc_reg + 12'd4;
			OP_SNER: if (vx != vy) next = pc_reg + 12'd4;
			OP_LD: begin
				wr = 1'b1;
				val = kk;
			end
			OP_ADD: begin
				wr = 1'b1;
				val = vx + kk;
			end
			OP_ALU: begin
				wr = 1'b1;
				case (n)
					ALU_MOV: val = vy;
					ALU_OR: val = vx | vy;
					ALU_AND: val = vx & vy;
					ALU_XOR: val = vx ^ vy;
					ALU_ADD: begin
						sum = {1'b0, vx} + {1'b0, vy};
						with_flag = 1'b1;
						flag = sum[8];
						val = sum[7:0];
					end
					ALU_SUB: begin
						with_flag = 1'b1;
						flag = vx > vy;
						val = vx - vy;
					end
					ALU_SHR: begin
						with_flag = 1'b1;
						flag = vx[0];
						val = vx >> 1;
					end
					ALU_SUBN: begin
						with_flag = 1'b1;
						flag = vy > vx;
						val = vy - vx;
					end
					ALU_SHL: begin
						with_flag = 1'b1;
						flag = vx[7];
						val = vx << 1;
					end
					default: begin
						wr = 1'b0;
						r.status = ST_UNSUP;
						next = pc_reg;
					end
				endcase
			end
			OP_LDI: i_reg = {4'h0, nnn};
			OP_JPV: next = nnn + {4'h0, v_regs[REG_V0]};
			OP_RND: begin
				wr = 1'b1;
				val = req.rand_val & kk;
			end
			OP_MISC: begin
				case (kk)
					F_LD_DT: begin
						wr = 1'b1;
						val = delay_reg;
					end
					F_SET_DT: delay_reg = vx;
					F_SET_ST: sound_reg = vx;
					F_ADD_I: i_reg = i_reg + {8'h00, vx};
					default: begin
						r.status = ST_UNSUP;
						next = pc_reg;
					end
				endcase
			end
			default: begin
				r.status = ST_UNSUP;
				next = pc_reg;
			end
		endcase
		// The flag lands first, so a destination of VF ends up holding the result.
		if (with_flag)
			v_regs[REG_VF] = {7'h00, flag};
		if (wr) begin
			v_regs[x] = val;
			r.reg_write = 1'b1;
			r.dest_reg = x;
			r.reg_value = val;
		end
		pc_reg = next;
		r.next_pc = pc_reg;
		r.flag_value = v_regs[REG_VF][0];
		r.index_value = i_reg;
		r.delay_value = delay_reg;
		r.sound_value = sound_reg;
		return r;
	endfunction

	// Mostly well-formed instructions, with skip operands made equal for SNE, SER and SNER, and a share of raw words.
	function automatic item_t random_instruction();
		item_t req;
		logic [3:0] x;
		logic [3:0] y;
		logic [3:0] n;
		logic [7:0] kk;
		int pick;
		int sub;
		req.instruction = 16'($urandom_range(65535));
		req.rand_val = 8'($urandom_range(255));
		x = req.instruction[11:8];
		kk = req.instruction[7:0];
		pick = $urandom_range(99);
		sub = $urandom_range(9);
		if (pick < 30) begin
			n = (sub < 8) ? 4'(sub) : ((sub == 8) ? ALU_SHL : req.rand_val[3:0]);
			req.instruction = {OP_ALU, req.instruction[11:4], n};
		end else if (pick < 42) begin
			req.instruction = {(sub < 5) ? OP_LD : OP_ADD, req.instruction[11:0]};
		end else if (pick < 54) begin
			if (sub[0])
				kk = v_regs[x];
			y = sub[1] ? x : req.instruction[7:4];
			case (sub % 4)
				0: req.instruction = {OP_SE, x, kk};
				1: req.instruction = {OP_SNE, x, kk};
				2: req.instruction = {OP_SER, x, y, req.instruction[3:0]};
				default: req.instruction = {OP_SNER, x, y, req.instruction[3:0]};
			endcase
		end else if (pick < 62) begin
			req.instruction = {OP_CALL, req.instruction[11:0]};
		end else if (pick < 70) begin
			req.instruction = {OP_SYS, SYS_RET};
		end else if (pick < 75) begin
			req.instruction = {sub[0] ? OP_JP : OP_JPV, req.instruction[11:0]};
		end else if (pick < 85) begin
			case (sub % 5)
				0: req.instruction = {OP_MISC, x, F_LD_DT};
				1: req.instruction = {OP_MISC, x, F_SET_DT};
				2: req.instruction = {OP_MISC, x, F_SET_ST};
				3: req.instruction = {OP_MISC, x, F_ADD_I};
				default: req.instruction = {OP_LDI, req.instruction[11:0]};
			endcase
		end else if (pick < 90) begin
			req.instruction = {OP_RND, req.instruction[11:0]};
		end else if (pick < 94) begin
			case (sub % 4)
				0: req.instruction = {OP_SYS, SYS_CLS};
				1: req.instruction = {OP_SYS, SYS_EXIT};
				2: req.instruction = {OP_SYS, SYS_HALT};
				default: req.instruction = {OP_SYS, req.instruction[11:0]};
			endcase
		end
		return req;
	endfunction

	function automatic string describe(result_t r);
		return $sformatf("pc=%h st=%0d wr=%b r%h=%h vf=%b i=%h dt=%h snd=%h",
			r.next_pc, r.status, r.reg_write, r.dest_reg, r.reg_value,
			r.flag_value, r.index_value, r.delay_value, r.sound_value);
	endfunction

	task automatic report_mismatch(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected %s, got %s", what, describe(want), describe(got));
	endtask

	// Valid is left high after a request goes through; the next request or idle cycle
	// decides it, so it is never written twice in one step.
	task automatic send_request(input item_t req, input bit typed, input result_t typed_want);
		result_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (item_stall);
		want = execute_instruction(req);
		exec_results_due.push_back(typed ? typed_want : want);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (exec_results_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_start_address(input logic [11:0] addr);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_start_address <= addr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pc_reg = addr;
	endtask

	// Receiver: random stalls, or a long hold-off each time one is requested.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_request != hold_seen) begin
				hold_seen = hold_request;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				if (exec_results_due.size() == 0) begin
					report_mismatch("result with nothing outstanding", '0, result);
				end else begin
					want = exec_results_due.pop_front();
					if (result.next_pc !== want.next_pc || result.status !== want.status ||
							result.reg_write !== want.reg_write ||
							result.dest_reg !== want.dest_reg ||
							result.reg_value !== want.reg_value ||
							result.flag_value !== want.flag_value ||
							result.index_value !== want.index_value ||
							result.delay_value !== want.delay_value ||
							result.sound_value !== want.sound_value)
						report_mismatch("result mismatch", want, result);
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("byte_vm_instruction_executor_core: mismatch");
				$finish;
			end
		end
	end

	initial begin
		item_t req;
		logic [11:0] bases [4];
		result_t none;
		none = '0;
		bases[0] = 12'h000;
		bases[1] = 12'hFFF;
		bases[2] = 12'($urandom_range(4095));
		bases[3] = START_ADDRESS_RST;
		for (int r = 0; r < 16; r++)
			v_regs[r] = 8'h00;
		for (int s = 0; s < DEF_STACK_DEPTH; s++)
			call_stack[s] = 12'h000;
		i_reg = 16'h0000;
		pc_reg = START_ADDRESS_RST;
		call_depth = 0;
		delay_reg = 8'h00;
		sound_reg = 8'h00;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			req.instruction = dir_words[i];
			req.rand_val = dir_random[i];
			send_request(req, i < TYPED_ROWS, (i < TYPED_ROWS) ? typed_results[i] : none);
		end

		for (int phase = 0; phase < 4; phase++) begin
			load_start_address(bases[phase]);
			send_idle_pct = (phase == 1) ? 62 : ((phase == 3) ? 15 : 0);
			recv_stall_pct = (phase == 2) ? 62 : ((phase == 3) ? 15 : 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Fill the stack past its depth, then unwind past empty.
				if (k == 40) begin
					for (int c = 0; c < BURST_CALLS; c++) begin
						req = random_instruction();
						req.instruction = {OP_CALL, req.instruction[11:0]};
						send_request(req, 1'b0, none);
					end
					for (int c = 0; c < BURST_CALLS; c++) begin
						req = random_instruction();
						req.instruction = {OP_SYS, SYS_RET};
						send_request(req, 1'b0, none);
					end
					k += 2 * BURST_CALLS;
				end
				if (phase == 0 && k == 100)
					hold_request++;
				if (phase == 2 && k == 150)
					drain_results();
				send_request(random_instruction(), 1'b0, none);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("byte_vm_instruction_executor_core: match");
		end else begin
			$display("byte_vm_instruction_executor_core: mismatch");
		end
		$finish;
	end

endmodule
